// File: sv/mtsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsv_pkg: shared types for the track stream validator
// Request/result payloads, configuration bundle, parse phases, status codes
// and the call-command check.
// ----------------------------------------------------------------------------
package mtsv_pkg;

  // Byte-code constants
  localparam logic [7:0] NOTE_MIN_BYTE = 8'h80;  // first byte that is not a length
  localparam logic [7:0] CMD_MIN_BYTE  = 8'hE0;  // first command code
  localparam logic [7:0] BAD_CODE_BYTE = 8'hFF;  // reserved code, an error wherever a code byte is expected
  localparam logic [7:0] CALL_CODE     = 8'hEF;  // subroutine call command

  localparam int unsigned CODE_LEN_W = 62;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TRACK_IS_SUB     = 2'd0,
    CFG_SUBROUTINE_COUNT = 2'd1,
    CFG_CODE_ARG_LENGTHS = 2'd2
  } cfg_idx_t;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = CODE_LEN_W;

  // Parse phase
  typedef enum logic [1:0] {
    PH_CODE      = 2'd0,
    PH_AFTER_LEN = 2'd1,
    PH_ARGS      = 2'd2
  } phase_t;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_BYTE  = 3'd1,
    ST_END_AFTER  = 3'd2,
    ST_CODE_FF    = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_NESTED     = 3'd5,
    ST_BAD_INDEX  = 3'd6,
    ST_ZERO_LOOPS = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       verdict_final;
  } out_rsp_t;

  typedef struct packed {
    logic                  track_is_sub;
    logic [15:0]           subroutine_count;
    logic [CODE_LEN_W-1:0] code_arg_lengths;
  } cfg_t;

  // Checks run when a call command completes
  function automatic status_t call_check(
    input logic        is_sub,
    input logic [15:0] sub_count,
    input logic [15:0] index,
    input logic        check_loops,
    input logic [7:0]  loop_count
  );
    status_t res;
    if (is_sub) begin
      res = ST_NESTED;
    end else if (index >= sub_count) begin
      res = ST_BAD_INDEX;
    end else if (check_loops && (loop_count == 8'd0)) begin
      res = ST_ZERO_LOOPS;
    end else begin
      res = ST_OK;
    end
    return res;
  endfunction

endpackage

// File: sv/mtsv_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsv_parse: per-byte parser state and error latch
// Holds the parse phase, argument counter, call index bytes and the latched
// error; one byte is consumed per step_en cycle.
// ----------------------------------------------------------------------------
module mtsv_parse import mtsv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  cfg_t    cfg,
  input  in_req_t req,
  output status_t status_o
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  args_left_r, args_left_nxt;
  logic        in_call_r, in_call_nxt;
  logic [1:0]  arg_pos_r, arg_pos_nxt;
  logic [7:0]  idx_lo_r, idx_lo_nxt;
  logic [7:0]  idx_hi_r, idx_hi_nxt;
  status_t     latched_r, latched_nxt;
  status_t     err;

  logic [7:0]  b;
  logic        last;
  logic [63:0] lengths_ext;
  logic [1:0]  code_nargs;
  logic        is_call;
  logic [7:0]  arg_lo, arg_hi;

  assign b           = req.data_byte;
  assign last        = req.last_byte;
  assign lengths_ext = {2'b00, cfg.code_arg_lengths};
  assign code_nargs  = lengths_ext[{b[4:0], 1'b0} +: 2];
  assign is_call     = (b == CALL_CODE);

  // Index bytes as they stand after this argument byte
  assign arg_lo = (arg_pos_r == 2'd0) ? b : idx_lo_r;
  assign arg_hi = (arg_pos_r == 2'd1) ? b : idx_hi_r;

  // Next parse state (ignoring the latch and end-of-track clear)
  always_comb begin
    phase_nxt     = phase_r;
    args_left_nxt = args_left_r;
    in_call_nxt   = in_call_r;
    arg_pos_nxt   = arg_pos_r;
    idx_lo_nxt    = idx_lo_r;
    idx_hi_nxt    = idx_hi_r;
    if (phase_r == PH_ARGS) begin
      idx_lo_nxt    = arg_lo;
      idx_hi_nxt    = arg_hi;
      args_left_nxt = args_left_r - 2'd1;
      arg_pos_nxt   = arg_pos_r + 2'd1;
      if (args_left_r == 2'd1) begin
        phase_nxt = PH_CODE;
      end
    end else if ((phase_r == PH_AFTER_LEN) && (b < NOTE_MIN_BYTE)) begin
      phase_nxt = PH_CODE;
    end else begin
      phase_nxt = PH_CODE;
      if (b < NOTE_MIN_BYTE) begin
        if (b != 8'd0) begin
          phase_nxt = PH_AFTER_LEN;
        end
      end else if ((b >= CMD_MIN_BYTE) && (b != BAD_CODE_BYTE)) begin
        in_call_nxt = is_call;
        idx_lo_nxt  = 8'd0;
        idx_hi_nxt  = 8'd0;
        arg_pos_nxt = 2'd0;
        if ((code_nargs != 2'd0) && !last) begin
          phase_nxt     = PH_ARGS;
          args_left_nxt = code_nargs;
        end
      end
    end
  end

  // Error raised by this byte
  always_comb begin
    err = ST_OK;
    if (phase_r == PH_ARGS) begin
      if (args_left_r == 2'd1) begin
        if (in_call_r) begin
          err = call_check(cfg.track_is_sub, cfg.subroutine_count, {arg_hi, arg_lo},
                           arg_pos_r >= 2'd2, b);
        end
      end else if (last) begin
        err = ST_INCOMPLETE;
      end
    end else if ((phase_r == PH_AFTER_LEN) && (b < NOTE_MIN_BYTE)) begin
      if (last) err = ST_END_AFTER;
    end else if (b < NOTE_MIN_BYTE) begin
      if (b == 8'd0) err = ST_ZERO_BYTE;
      else if (last) err = ST_END_AFTER;
    end else if (b >= CMD_MIN_BYTE) begin
      if (b == BAD_CODE_BYTE) begin
        err = ST_CODE_FF;
      end else if (code_nargs == 2'd0) begin
        if (is_call) begin
          err = call_check(cfg.track_is_sub, cfg.subroutine_count, 16'd0, 1'b0, 8'd0);
        end
      end else if (last) begin
        err = ST_INCOMPLETE;
      end
    end
  end

  // First error wins
  assign latched_nxt = ((latched_r == ST_OK) && (err != ST_OK)) ? err : latched_r;
  assign status_o    = latched_nxt;

  // State registers: frozen while an error is latched, cleared at track end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CODE;
      args_left_r <= 2'd0;
      in_call_r   <= 1'b0;
      arg_pos_r   <= 2'd0;
      idx_lo_r    <= 8'd0;
      idx_hi_r    <= 8'd0;
      latched_r   <= ST_OK;
    end else if (step_en) begin
      if (last) begin
        phase_r     <= PH_CODE;
        args_left_r <= 2'd0;
        in_call_r   <= 1'b0;
        arg_pos_r   <= 2'd0;
        idx_lo_r    <= 8'd0;
        idx_hi_r    <= 8'd0;
        latched_r   <= ST_OK;
      end else if (latched_r == ST_OK) begin
        phase_r     <= phase_nxt;
        args_left_r <= args_left_nxt;
        in_call_r   <= in_call_nxt;
        arg_pos_r   <= arg_pos_nxt;
        idx_lo_r    <= idx_lo_nxt;
        idx_hi_r    <= idx_hi_nxt;
        latched_r   <= latched_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // Track end leaves a clean parser
  a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && last |=> (latched_r == ST_OK) && (phase_r == PH_CODE))
    else $error("parser not cleared after last byte");

  // A latched error is held until the last byte
  a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (latched_r != ST_OK) && !(step_en && last) |=> $stable(latched_r))
    else $error("latched error changed before track end");

  // Reported status never drops a latched error
  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (latched_r != ST_OK) |-> (status_o == latched_r))
    else $error("status lost latched error");
`endif

endmodule

// File: sv/music_track_stream_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_track_stream_validator_unit: sequencer track byte checker
// Input register, combinational parse step, result register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_data  (data_byte, last_byte)
//  out_    | output    | out_valid/out_stall | out_data (status, verdict_final)
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_stall is low; out_valid rises once
// the request has passed the input register and the parse step into the
// result register.
// The parse state update is the single loop: one byte per clock while not stalled.
// Reset (rst_n low, synchronous) clears the parser, the pipeline valids and
// all configuration registers. An out_stall holds the result register and,
// once the input register is also full, raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module music_track_stream_validator_unit import mtsv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_req_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_rsp_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t     cfg_r;
  logic     s1_valid_r;
  in_req_t  s1_data_r;
  logic     out_valid_r;
  out_rsp_t out_data_r;
  logic     advance;
  logic     in_accept;
  status_t  step_status;

  // Pipeline control
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRACK_IS_SUB:     cfg_r.track_is_sub     <= cfg_wdata[0];
        CFG_SUBROUTINE_COUNT: cfg_r.subroutine_count <= cfg_wdata[15:0];
        CFG_CODE_ARG_LENGTHS: cfg_r.code_arg_lengths <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
  end

  mtsv_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .cfg      (cfg_r),
    .req      (s1_data_r),
    .status_o (step_status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.status        <= step_status;
      out_data_r.verdict_final <= s1_data_r.last_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A parse step always lands in the result register
  a_step_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("parse step produced no result");

  // A request in the input register is never dropped
  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_data_r))
    else $error("pending request lost");

  // Input is only stalled when the input register cannot drain
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without cause");
`endif

endmodule
